/* hdl/rfc_pkg.sv */
// Shared types, codes and byte-layout helpers for the RGBA8888 format converter.
// No dependencies; every other file of the converter imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

	// Pipeline shape: one front stage, a row of divider cells, one pack stage.
	localparam int NUM_CELLS  = 8;
	localparam int NUM_STAGES = NUM_CELLS + 2;
	localparam int OCC_W      = $clog2(NUM_STAGES + 1);

	// Format codes.
	localparam logic [2:0] FMT_NATIVE_PM = 3'd0;
	localparam logic [2:0] FMT_LAST      = 3'd5;

	// Byte-order field of a format code (code >> 1).
	localparam logic [1:0] ORDER_NATIVE = 2'd0;
	localparam logic [1:0] ORDER_BGRA   = 2'd1;

	// Configuration register indexes.
	localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [1:0] REG_DEST_FORMAT   = 2'd1;
	localparam logic [1:0] REG_NATIVE_ORDER  = 2'd2;

	// What the pack stage does with an item.
	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_CONV = 2'd2;

	localparam logic [7:0] CHANNEL_MAX = 8'hff;
	localparam logic [7:0] PREMUL_BIAS = 8'd254;

	// Byte positions of each channel, byte 0 least significant.
	typedef struct packed {
		logic [1:0] a;
		logic [1:0] r;
		logic [1:0] g;
		logic [1:0] b;
	} layout_t;

	localparam layout_t LAY_BGRA = '{a: 2'd3, r: 2'd2, g: 2'd1, b: 2'd0};
	localparam layout_t LAY_RGBA = '{a: 2'd3, r: 2'd0, g: 2'd1, b: 2'd2};

	typedef struct packed {
		logic [2:0] src;
		logic [2:0] dst;
		logic       native;
	} cfg_t;

	// One item in flight. Channel lanes: 0 red, 1 green, 2 blue.
	// rem/quo hold the partial remainder and the shifting dividend/quotient word.
	typedef struct packed {
		logic [1:0]      mode;
		logic [31:0]     pixel;
		layout_t         dst;
		logic [7:0]      alpha;
		logic [7:0]      divisor;
		logic [2:0]      sat;
		logic [2:0][7:0] rem;
		logic [2:0][7:0] quo;
	} item_t;

	function automatic layout_t layout_of(input logic [2:0] code, input logic native);
		layout_t lay;
		case (code[2:1])
			ORDER_NATIVE: lay = native ? LAY_RGBA : LAY_BGRA;
			ORDER_BGRA:   lay = LAY_BGRA;
			default:      lay = LAY_RGBA;
		endcase
		return lay;
	endfunction

	function automatic logic [7:0] get_byte(input logic [31:0] px, input logic [1:0] pos);
		return px[{pos, 3'b000} +: 8];
	endfunction

	function automatic logic [31:0] put_pixel(input layout_t lay, input logic [7:0] a,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [31:0] res;
		res = '0;
		for (int k = 0; k < 4; k++) begin
			if (lay.a == 2'(k))
				res[k*8 +: 8] = a;
			else if (lay.r == 2'(k))
				res[k*8 +: 8] = r;
			else if (lay.g == 2'(k))
				res[k*8 +: 8] = g;
			else if (lay.b == 2'(k))
				res[k*8 +: 8] = b;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hdl/rgba8888_format_converter.sv */
// Top level of the RGBA8888 format converter: configuration registers and the
// pipeline front -> divider cells -> pack. Depends on rfc_pkg and all rfc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Converts one 32-bit pixel per item between native, BGRA and RGBA byte orders,
// premultiplied or not. The block takes one item every cycle unless a stalled output
// backs up to its input. There are ten register stages: one front stage (unpack and an
// 8x8 multiply per channel), a row of eight divider cells that each settle one quotient
// bit, and one output register. Every stage has its own valid bit, so a stalled output
// only holds back the stages behind a full one and the empty stages keep filling. All
// three conversions share the divider: unpremultiply divides c*255 by alpha (channels
// above alpha saturate to 255, alpha zero gives a zero pixel), premultiply divides
// c*alpha+254 by 255, and a plain reorder divides c*255 by 255. Equal source and
// destination codes pass the pixel untouched; any other pairing with code 6 or 7 gives
// zero. Configuration writes are always taken (cfg_ready is high) and must only come
// while no item is in flight.
module rgba8888_format_converter import rfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] in_pixel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_pixel
);

	logic [2:0] source_format_q;
	logic [2:0] dest_format_q;
	logic       native_order_q;
	cfg_t       cfg;

	// stage k feeds cell k; index NUM_CELLS feeds the pack stage
	logic  chain_valid [NUM_CELLS+1];
	logic  chain_ready [NUM_CELLS+1];
	item_t chain_item  [NUM_CELLS+1];

	logic [OCC_W-1:0] occ_q;

	// ---- configuration registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_NATIVE_PM;
			dest_format_q   <= FMT_NATIVE_PM;
			native_order_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SOURCE_FORMAT: source_format_q <= cfg_data;
				REG_DEST_FORMAT:   dest_format_q   <= cfg_data;
				REG_NATIVE_ORDER:  native_order_q  <= cfg_data[0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = '{src: source_format_q, dst: dest_format_q, native: native_order_q};

	// ---- pipeline ----
	rfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.pixel    (in_pixel),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_item  (chain_item[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rfc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_item  (chain_item[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_item  (chain_item[i+1])
		);
	end

	rfc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (chain_valid[NUM_CELLS]),
		.up_ready  (chain_ready[NUM_CELLS]),
		.up_item   (chain_item[NUM_CELLS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel)
	);

	// ---- items in flight, for checking ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	// an empty output register lets every stage move, so input is open
	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(NUM_STAGES))
		else $error("more items in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !out_valid)
		else $error("result shown with no item in flight");

endmodule

`default_nettype wire

/* hdl/rfc_front.sv */
// Front stage: unpacks the source pixel, decides the item's mode and forms the
// 16-bit dividend and the divisor of each channel. Depends on rfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfc_front import rfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire logic [31:0] pixel,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output item_t            dn_item
);

	layout_t     src_lay;
	logic [7:0]  alpha;
	logic [2:0][7:0] chan;
	logic        unpremul;
	logic        premul;
	logic [7:0]  mul_op;
	logic [15:0] num [3];
	item_t       item;
	logic        valid_s1;
	item_t       item_s1;

	always_comb begin
		src_lay  = layout_of(cfg.src, cfg.native);
		alpha    = get_byte(pixel, src_lay.a);
		chan[0]  = get_byte(pixel, src_lay.r);
		chan[1]  = get_byte(pixel, src_lay.g);
		chan[2]  = get_byte(pixel, src_lay.b);
		unpremul = !cfg.src[0] && cfg.dst[0];
		premul   = cfg.src[0] && !cfg.dst[0];
		// premul: (c*a + 254) / 255; unpremul: c*255 / a; reorder: c*255 / 255
		mul_op   = premul ? alpha : CHANNEL_MAX;

		item         = '0;
		item.pixel   = pixel;
		item.dst     = layout_of(cfg.dst, cfg.native);
		item.alpha   = alpha;
		item.divisor = unpremul ? alpha : CHANNEL_MAX;
		if (cfg.src == cfg.dst)
			item.mode = MODE_PASS;
		else if (cfg.src > FMT_LAST || cfg.dst > FMT_LAST)
			item.mode = MODE_ZERO;
		else if (unpremul && alpha == 8'd0)
			item.mode = MODE_ZERO;
		else
			item.mode = MODE_CONV;

		for (int k = 0; k < 3; k++) begin
			num[k] = ({8'd0, chan[k]} * {8'd0, mul_op})
				+ {8'd0, (premul ? PREMUL_BIAS : 8'd0)};
			// quotient exceeds 255 exactly when the channel is above alpha
			item.sat[k] = unpremul && (chan[k] > alpha);
			item.rem[k] = num[k][15:8];
			item.quo[k] = num[k][7:0];
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_s1 <= item;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

endmodule

`default_nettype wire

/* hdl/rfc_div_cell.sv */
// One divider-row cell: a restoring step per channel lane, producing one quotient
// bit per cycle unless stalled and handing the item downstream. Depends on rfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfc_div_cell import rfc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire item_t up_item,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output item_t      dn_item
);

	logic [8:0] trial [3];
	logic [8:0] diff  [3];
	logic [2:0] ge;
	item_t      nxt;
	logic       valid_q;
	item_t      item_q;

	always_comb begin
		nxt = up_item;
		for (int k = 0; k < 3; k++) begin
			trial[k]   = {up_item.rem[k], up_item.quo[k][7]};
			diff[k]    = trial[k] - {1'b0, up_item.divisor};
			ge[k]      = trial[k] >= {1'b0, up_item.divisor};
			nxt.rem[k] = ge[k] ? diff[k][7:0] : trial[k][7:0];
			nxt.quo[k] = {up_item.quo[k][6:0], ge[k]};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

`default_nettype wire

/* hdl/rfc_pack.sv */
// Output stage: saturates and packs the quotients by the destination layout, or
// passes or zeroes the pixel; holds the result until taken. Depends on rfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfc_pack import rfc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire item_t up_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [31:0] out_pixel
);

	logic [2:0][7:0] chan;
	logic [31:0]     res;
	logic            valid_q;
	logic [31:0]     pixel_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			chan[k] = up_item.sat[k] ? CHANNEL_MAX : up_item.quo[k];
		end
		case (up_item.mode)
			MODE_PASS: res = up_item.pixel;
			MODE_CONV: res = put_pixel(up_item.dst, up_item.alpha, chan[0], chan[1], chan[2]);
			default:   res = '0;
		endcase
	end

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			pixel_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_pixel = pixel_q;

endmodule

`default_nettype wire

/* tb/rgba8888_format_converter_checker.sv */
// Checker for the RGBA8888 format converter: tracks the register writes, predicts
// each converted pixel and compares it with what leaves the block. Depends on rfc_pkg.
`timescale 1ns / 1ps

module rgba8888_format_converter_checker import rfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [31:0] in_pixel,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] out_pixel,
	output int               error_count,
	output int               pixels_pending
);

	logic [2:0]  src_fmt = FMT_NATIVE_PM;
	logic [2:0]  dst_fmt = FMT_NATIVE_PM;
	logic        native_rgba = 1'b0;
	logic [31:0] expected_pixels [$];
	logic [31:0] oldest;
	int          errors = 0;

	function automatic layout_t layout_for(input logic [2:0] code, input logic nat);
		if (code[2:1] == ORDER_NATIVE)
			return nat ? LAY_RGBA : LAY_BGRA;
		else if (code[2:1] == ORDER_BGRA)
			return LAY_BGRA;
		return LAY_RGBA;
	endfunction

	function automatic int byte_at(input logic [31:0] px, input logic [1:0] pos);
		return int'((px >> (8 * pos)) & 32'hff);
	endfunction

	function automatic logic [31:0] predict_pixel(input logic [2:0] src, input logic [2:0] dst,
		input logic nat, input logic [31:0] px);
		layout_t     sl;
		layout_t     dl;
		int          a;
		int          ch [3];
		int          q;
		logic [31:0] res;
		if (src == dst)
			return px;
		if (src > FMT_LAST || dst > FMT_LAST)
			return '0;
		sl = layout_for(src, nat);
		dl = layout_for(dst, nat);
		a = byte_at(px, sl.a);
		ch[0] = byte_at(px, sl.r);
		ch[1] = byte_at(px, sl.g);
		ch[2] = byte_at(px, sl.b);
		// bit 0 of a format code set means unpremultiplied
		if (!src[0] && dst[0]) begin
			if (a == 0)
				return '0;
			for (int k = 0; k < 3; k++) begin
				q = ch[k] * 255 / a;
				ch[k] = (q > 255) ? 255 : q;
			end
		end else if (src[0] && !dst[0]) begin
			for (int k = 0; k < 3; k++)
				ch[k] = (ch[k] * a + 254) / 255;
		end
		res = '0;
		res |= 32'(a) << (8 * dl.a);
		res |= 32'(ch[0]) << (8 * dl.r);
		res |= 32'(ch[1]) << (8 * dl.g);
		res |= 32'(ch[2]) << (8 * dl.b);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt = FMT_NATIVE_PM;
			dst_fmt = FMT_NATIVE_PM;
			native_rgba = 1'b0;
			expected_pixels.delete();
			errors = 0;
			error_count <= 0;
			pixels_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_FORMAT: src_fmt = cfg_data;
					REG_DEST_FORMAT:   dst_fmt = cfg_data;
					REG_NATIVE_ORDER:  native_rgba = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_pixels.push_back(predict_pixel(src_fmt, dst_fmt, native_rgba, in_pixel));
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$error("out_pixel: expected none, actual %h", out_pixel);
				end else begin
					oldest = expected_pixels.pop_front();
					if (out_pixel !== oldest) begin
						errors++;
						$error("out_pixel: expected %h, actual %h", oldest, out_pixel);
					end
				end
			end
			error_count <= errors;
			pixels_pending <= expected_pixels.size();
		end
	end

endmodule

/* tb/rgba8888_format_converter_test.sv */
// Test top for the RGBA8888 format converter: clock, reset, register writes, pixel
// stimulus and output back-pressure. Depends on rfc_pkg, the converter and its checker.
`timescale 1ns / 1ps

module rgba8888_format_converter_test import rfc_pkg::*;;

	// Format codes beyond the two the package names.
	localparam logic [2:0] FMT_NATIVE_UN = 3'd1;
	localparam logic [2:0] FMT_BGRA_PM   = 3'd2;
	localparam logic [2:0] FMT_BGRA_UN   = 3'd3;
	localparam logic [2:0] FMT_RGBA_PM   = 3'd4;
	localparam logic [2:0] FMT_RGBA_UN   = 3'd5;
	localparam logic [2:0] FMT_BAD_6     = 3'd6;
	localparam logic [2:0] FMT_BAD_7     = 3'd7;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	// Pipeline is ten stages deep; the settle time is derived from the stage count.
	localparam int SETTLE_CYCLES = 2 * NUM_STAGES;
	localparam int RANDOM_ITEMS  = 1050;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [2:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] in_pixel = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_pixel;

	int error_count;
	int pixels_pending;
	bit no_idle = 1'b0;
	int items_sent = 0;

	logic [2:0] good_codes [6] = '{FMT_NATIVE_PM, FMT_NATIVE_UN, FMT_BGRA_PM,
		FMT_BGRA_UN, FMT_RGBA_PM, FMT_RGBA_UN};

	rgba8888_format_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_pixel  (in_pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel)
	);

	rgba8888_format_converter_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_pixel       (in_pixel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_pixel      (out_pixel),
		.error_count    (error_count),
		.pixels_pending (pixels_pending)
	);

	always #5 clk = ~clk;

	// Idle length: half none, most of the rest short, a few long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random pixel. Alpha sits in byte 3 in every layout, so well-formed premultiplied
	// pixels (channels not above alpha) are easy to build; the rest hit corners and noise.
	function automatic logic [31:0] make_pixel();
		logic [7:0] a;
		logic [7:0] ch [3];
		logic [7:0] corner [6];
		corner = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: begin
				a = 8'($urandom_range(0, 255));
				for (int k = 0; k < 3; k++)
					ch[k] = 8'($urandom_range(0, a));
			end
			7: begin
				a = $urandom_range(0, 1) ? 8'hff : 8'h00;
				for (int k = 0; k < 3; k++)
					ch[k] = 8'($urandom_range(0, 255));
			end
			8: begin
				a = corner[$urandom_range(0, 5)];
				for (int k = 0; k < 3; k++)
					ch[k] = corner[$urandom_range(0, 5)];
			end
			default: begin
				// channel equal to alpha or just above it
				a = 8'($urandom_range(0, 254));
				for (int k = 0; k < 3; k++)
					ch[k] = a + 8'($urandom_range(0, 1));
			end
		endcase
		return {a, ch[2], ch[1], ch[0]};
	endfunction

	// One pixel item. Valid only drops when a gap is taken, so back-to-back items
	// keep it high across the accepting edge.
	task automatic send_pixel(input logic [31:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= px;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Let every expected pixel come out, then let the pipe go quiet.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// New setting, only while the block is empty. The native order write carries
	// random upper bits, which the block must ignore.
	task automatic set_formats(input logic [2:0] src, input logic [2:0] dst,
		input logic nat);
		wait_drained();
		write_reg(REG_SOURCE_FORMAT, src);
		write_reg(REG_DEST_FORMAT, dst);
		write_reg(REG_NATIVE_ORDER, {2'($urandom_range(0, 3)), nat});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output side back-pressure, independent of the input side.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		logic [2:0] src;
		logic [2:0] dst;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: native premultiplied both ways, pixel passes through.
		send_pixel(32'h12345678);
		send_pixel(32'hffffffff);

		// Premultiplied to unpremultiplied: alpha zero, channel above alpha, extremes.
		set_formats(FMT_NATIVE_PM, FMT_NATIVE_UN, 1'b0);
		send_pixel(32'h00000000);
		send_pixel(32'h00123456);
		send_pixel(32'h80ff4020);
		send_pixel(32'hffffffff);
		send_pixel(32'h80402010);
		send_pixel(32'h01010000);

		// Unpremultiplied to premultiplied with a byte-order change.
		set_formats(FMT_RGBA_UN, FMT_BGRA_PM, 1'b1);
		send_pixel(32'hffffffff);
		send_pixel(32'h00ffffff);
		send_pixel(32'h7f80ff01);
		send_pixel(32'hff000000);

		// Same alpha mode: reorder only.
		set_formats(FMT_BGRA_PM, FMT_RGBA_PM, 1'b0);
		send_pixel(32'h11223344);
		send_pixel(32'ha5c3e10f);

		// Native taken as RGBA, so no byte moves.
		set_formats(FMT_NATIVE_UN, FMT_RGBA_UN, 1'b1);
		send_pixel(32'h89abcdef);

		// Equal codes pass; the unused index is written here too.
		set_formats(FMT_BGRA_UN, FMT_BGRA_UN, 1'b0);
		write_reg(REG_UNUSED, 3'($urandom_range(0, 7)));
		cfg_valid <= 1'b0;
		send_pixel(32'hdeadbeef);
		send_pixel(32'hffffffff);

		// Invalid codes: zero unless both codes are equal.
		set_formats(FMT_BAD_6, FMT_NATIVE_UN, 1'b0);
		send_pixel(32'h12345678);
		set_formats(FMT_NATIVE_PM, FMT_BAD_7, 1'b1);
		send_pixel(32'hffffffff);
		set_formats(FMT_BAD_7, FMT_BAD_7, 1'b0);
		send_pixel(32'hcafef00d);
		set_formats(FMT_BAD_6, FMT_BAD_7, 1'b1);
		send_pixel(32'hffffffff);

		// Random phases: random setting, then a burst of random pixels.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			src = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? FMT_BAD_6 : FMT_BAD_7)
				: good_codes[$urandom_range(0, 5)];
			dst = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? FMT_BAD_6 : FMT_BAD_7)
				: good_codes[$urandom_range(0, 5)];
			set_formats(src, dst, 1'($urandom_range(0, 1)));
			no_idle = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 36);
			repeat (n) send_pixel(make_pixel());
		end
		no_idle = 1'b0;

		wait_drained();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hang guard, several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* rgba8888_format_converter.f */
hdl/rfc_pkg.sv
hdl/rfc_front.sv
hdl/rfc_div_cell.sv
hdl/rfc_pack.sv
hdl/rgba8888_format_converter.sv
tb/rgba8888_format_converter_checker.sv
tb/rgba8888_format_converter_test.sv
